[sv/scc_pkg.sv]
`default_nettype none
package scc_pkg;

    localparam int ENTRIES_DEF      = 64;
    localparam int SECTOR_BYTES_DEF = 512;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [1:0] FILL_NONE   = 2'd0;
    localparam logic [1:0] FILL_DEVICE = 2'd1;
    localparam logic [1:0] FILL_ZERO   = 2'd2;

    typedef struct packed {
        logic [5:0]  slot;
        logic        hit;
        logic [1:0]  fill_kind;
        logic        evict_valid;
        logic [31:0] evict_sector;
        logic        write_back;
        logic [14:0] data_address;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_MISS,
        S_SWEEP,
        S_VICT,
        S_FL_RD,
        S_FL_CAP,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

[sv/scc_if.sv]
`default_nettype none
interface scc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] sector_number;
    logic [8:0]  byte_offset;
    logic [9:0]  chunk_length;
    logic [9:0]  bytes_remaining;

    modport source (output valid, action, sector_number, byte_offset, chunk_length,
                    bytes_remaining, input ready);
    modport sink (input valid, action, sector_number, byte_offset, chunk_length,
                  bytes_remaining, output ready);
endinterface

interface scc_res_if;
    logic        valid;
    logic        ready;
    logic [5:0]  slot;
    logic        hit;
    logic [1:0]  fill_kind;
    logic        evict_valid;
    logic [31:0] evict_sector;
    logic        write_back;
    logic [14:0] data_address;
    logic        last;

    modport source (output valid, slot, hit, fill_kind, evict_valid, evict_sector,
                    write_back, data_address, last, input ready);
    modport sink (input valid, slot, hit, fill_kind, evict_valid, evict_sector,
                  write_back, data_address, last, output ready);
endinterface
`default_nettype wire

[sv/sector_cache_clock_policy.sv]
`default_nettype none
// Channel   Direction  Carries
// i_req     in         action, sector number, byte offset, chunk length, bytes remaining
// o_res     out        slot, hit, fill kind, eviction, write-back, data address, last
//
// A read or write scans the tag memory, one entry per cycle, until a hit or the last valid entry;
// a miss takes the next free slot, or, on a full cache, a clock sweep picks the victim.
// A flush reads, captures and outputs each valid entry in turn through the tag memory.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A new request is taken once the previous one has left for the output register.
module sector_cache_clock_policy #(
    parameter int ENTRIES      = scc_pkg::ENTRIES_DEF,
    parameter int SECTOR_BYTES = scc_pkg::SECTOR_BYTES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    scc_req_if.sink    i_req,
    scc_res_if.source  o_res
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int AW  = IW + $clog2(SECTOR_BYTES) + 1;
    localparam int AWX = (AW > 10) ? AW : 10;

    function automatic logic [14:0] f_addr(input logic [IW-1:0] s, input logic [8:0] off);
        logic [AWX-1:0] p;
        p = AWX'(s) * AWX'(SECTOR_BYTES) + AWX'(off);
        return 15'(p);
    endfunction

    scc_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic            r_issue, n_issue;
    logic [IW-1:0]   r_cmp_idx;
    logic            r_cmp_v;
    logic [CW-1:0]   r_count, n_count;
    logic [IW-1:0]   r_hand, n_hand;
    logic [ENTRIES-1:0] r_dirty, n_dirty, r_ref, n_ref;
    scc_pkg::t_res   r_res, n_res, r_out, n_out;
    logic            r_oval, n_oval;
    logic            r_flush, n_flush;

    logic [1:0]      r_act;
    logic [31:0]     r_sec;
    logic [8:0]      r_off;
    logic [9:0]      r_chunk, r_rem;

    logic [31:0]     r_sector_mem [ENTRIES];
    logic [31:0]     r_rd_data;
    logic            mem_we, mem_re;
    logic [IW-1:0]   mem_wa, mem_ra;
    logic            accept;
    logic [1:0]      miss_fill;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == scc_pkg::S_IDLE);

    assign o_res.valid        = r_oval;
    assign o_res.slot         = r_out.slot;
    assign o_res.hit          = r_out.hit;
    assign o_res.fill_kind    = r_out.fill_kind;
    assign o_res.evict_valid  = r_out.evict_valid;
    assign o_res.evict_sector = r_out.evict_sector;
    assign o_res.write_back   = r_out.write_back;
    assign o_res.data_address = r_out.data_address;
    assign o_res.last         = r_out.last;

    assign miss_fill = (r_act == scc_pkg::ACT_READ) ? scc_pkg::FILL_DEVICE :
                       ((r_off != 9'd0 || r_chunk < r_rem) ? scc_pkg::FILL_DEVICE
                                                           : scc_pkg::FILL_ZERO);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_sector_mem[mem_wa] <= r_sec;
        end
        if (mem_re) begin
            r_rd_data <= r_sector_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scc_pkg::S_IDLE;
            r_count <= '0;
            r_hand  <= '0;
            r_dirty <= '0;
            r_ref   <= '0;
            r_oval  <= 1'b0;
            r_issue <= 1'b0;
            r_cmp_v <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_hand  <= n_hand;
            r_dirty <= n_dirty;
            r_ref   <= n_ref;
            r_oval  <= n_oval;
            r_issue <= n_issue;
            r_cmp_v <= r_issue && (r_state == scc_pkg::S_SRCH);
            r_flush <= n_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmp_idx <= r_idx;
        r_res     <= n_res;
        r_out     <= n_out;
        if (accept) begin
            r_act   <= i_req.action;
            r_sec   <= i_req.sector_number;
            r_off   <= i_req.byte_offset;
            r_chunk <= i_req.chunk_length;
            r_rem   <= i_req.bytes_remaining;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_issue = 1'b0;
        n_count = r_count;
        n_hand  = r_hand;
        n_dirty = r_dirty;
        n_ref   = r_ref;
        n_res   = r_res;
        n_out   = r_out;
        n_flush = r_flush;
        n_oval  = r_oval && !o_res.ready;
        mem_we  = 1'b0;
        mem_wa  = r_idx;
        mem_re  = 1'b0;
        mem_ra  = r_idx;

        case (r_state)
            scc_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_flush = 1'b0;
                    case (i_req.action)
                        scc_pkg::ACT_READ, scc_pkg::ACT_WRITE: begin
                            if (r_count == '0) begin
                                n_state = scc_pkg::S_MISS;
                            end else begin
                                n_state = scc_pkg::S_SRCH;
                                n_issue = 1'b1;
                            end
                        end
                        scc_pkg::ACT_FLUSH: begin
                            n_flush = 1'b1;
                            if (r_count == '0) begin
                                n_res      = '0;
                                n_res.last = 1'b1;
                                n_state    = scc_pkg::S_OUT;
                            end else begin
                                n_state = scc_pkg::S_FL_RD;
                            end
                        end
                        default: begin
                            n_state = scc_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            scc_pkg::S_SRCH: begin
                // Reads are issued back to back; each compare happens in the cycle after its read is issued.
                mem_re  = r_issue;
                n_issue = r_issue && (r_idx != IW'(r_count - 1'b1));
                if (r_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_cmp_v && r_rd_data == r_sec) begin
                    n_ref[r_cmp_idx] = 1'b1;
                    if (r_act == scc_pkg::ACT_WRITE) begin
                        n_dirty[r_cmp_idx] = 1'b1;
                    end
                    n_res              = '0;
                    n_res.slot         = 6'(r_cmp_idx);
                    n_res.hit          = 1'b1;
                    n_res.data_address = f_addr(r_cmp_idx, r_off);
                    n_res.last         = 1'b1;
                    n_issue            = 1'b0;
                    n_state            = scc_pkg::S_OUT;
                end else if (r_cmp_v && r_cmp_idx == IW'(r_count - 1'b1)) begin
                    n_issue = 1'b0;
                    n_state = scc_pkg::S_MISS;
                end
            end
            scc_pkg::S_MISS: begin
                if (r_count < CW'(ENTRIES)) begin
                    mem_we             = 1'b1;
                    mem_wa             = IW'(r_count);
                    n_count            = r_count + 1'b1;
                    n_ref[IW'(r_count)]   = 1'b0;
                    n_dirty[IW'(r_count)] = (r_act == scc_pkg::ACT_WRITE);
                    n_res              = '0;
                    n_res.slot         = 6'(IW'(r_count));
                    n_res.fill_kind    = miss_fill;
                    n_res.data_address = f_addr(IW'(r_count), r_off);
                    n_res.last         = 1'b1;
                    n_state            = scc_pkg::S_OUT;
                end else begin
                    n_idx   = r_hand;
                    n_state = scc_pkg::S_SWEEP;
                end
            end
            scc_pkg::S_SWEEP: begin
                if (r_ref[r_idx]) begin
                    n_ref[r_idx] = 1'b0;
                    n_idx = (r_idx == IW'(ENTRIES - 1)) ? '0 : r_idx + 1'b1;
                end else begin
                    mem_re  = 1'b1;
                    n_state = scc_pkg::S_VICT;
                end
            end
            scc_pkg::S_VICT: begin
                mem_we             = 1'b1;
                n_res              = '0;
                n_res.slot         = 6'(r_idx);
                n_res.fill_kind    = miss_fill;
                n_res.evict_valid  = 1'b1;
                n_res.evict_sector = r_rd_data;
                n_res.write_back   = r_dirty[r_idx];
                n_res.data_address = f_addr(r_idx, r_off);
                n_res.last         = 1'b1;
                n_ref[r_idx]       = 1'b0;
                n_dirty[r_idx]     = (r_act == scc_pkg::ACT_WRITE);
                n_hand  = (r_idx == IW'(ENTRIES - 1)) ? '0 : r_idx + 1'b1;
                n_state = scc_pkg::S_OUT;
            end
            scc_pkg::S_FL_RD: begin
                mem_re  = 1'b1;
                n_state = scc_pkg::S_FL_CAP;
            end
            scc_pkg::S_FL_CAP: begin
                // Valid entries always occupy the slots below the fill count.
                n_res              = '0;
                n_res.slot         = 6'(r_idx);
                n_res.evict_valid  = 1'b1;
                n_res.evict_sector = r_rd_data;
                n_res.write_back   = r_dirty[r_idx];
                n_res.data_address = f_addr(r_idx, 9'd0);
                n_res.last         = (r_idx == IW'(r_count - 1'b1));
                n_dirty[r_idx]     = 1'b0;
                n_ref[r_idx]       = 1'b0;
                n_state            = scc_pkg::S_OUT;
            end
            scc_pkg::S_OUT: begin
                if (!r_oval || o_res.ready) begin
                    n_oval = 1'b1;
                    n_out  = r_res;
                    if (r_flush && !r_res.last) begin
                        n_idx   = r_idx + 1'b1;
                        n_state = scc_pkg::S_FL_RD;
                    end else begin
                        if (r_flush) begin
                            n_count = '0;
                            n_hand  = '0;
                        end
                        n_state = scc_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = scc_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("fill count beyond cache size");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hand) < ENTRIES)
        else $error("clock hand out of range");

    a_sweep_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scc_pkg::S_SWEEP) |-> (r_count == CW'(ENTRIES)))
        else $error("sweep on a cache that is not full");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scc_pkg::S_OUT && r_flush && r_res.last && (!r_oval || o_res.ready))
        |=> (r_count == '0 && r_hand == '0))
        else $error("flush did not empty the cache");
`endif

endmodule
`default_nettype wire
